/* rtl/rcm_pkg.sv */
// Shared types and constants for the reliability-aware core mapper.
package rcm_pkg;

  localparam int CORE_ROWS    = 4;
  localparam int CORE_COLUMNS = 4;
  localparam int MAX_CORES    = 16;
  localparam int NUM_CORES    = (CORE_ROWS * CORE_COLUMNS > MAX_CORES) ?
                                MAX_CORES : CORE_ROWS * CORE_COLUMNS;

  localparam int CORE_W = 4;
  localparam int CNT_W  = 5;
  localparam int REL_W  = 16;
  localparam int MASK_W = 16;

  localparam logic [CNT_W-1:0]  NUM_CORES_C = CNT_W'(NUM_CORES);
  localparam logic [MASK_W-1:0] CORE_MASK   = MASK_W'((33'd1 << NUM_CORES) - 33'd1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_UPDATE = 2'd0,
    MODE_MAP    = 2'd1,
    MODE_SWEEP  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OP_UPDATE,
    OP_EMPTY,
    OP_FAIL,
    OP_MAP,
    OP_SWEEP
  } cmd_op_e;

  typedef enum logic [2:0] {
    KIND_ASSIGN  = 3'd0,
    KIND_FAIL    = 3'd1,
    KIND_EMPTY   = 3'd2,
    KIND_MIGRATE = 3'd3,
    KIND_DONE    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_CHECK_WAIT,
    ST_NEXT_SRC,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    cmd_op_e           op;
    logic [CORE_W-1:0] core_index;
    logic [REL_W-1:0]  reliability;
    logic [CNT_W-1:0]  core_count;
    logic [MASK_W-1:0] free_mask;
    logic [MASK_W-1:0] active_mask;
  } cmd_t;

  localparam int CFG_ADDR_W = 3;
  localparam logic CFG_IDX_THRESHOLD = 1'b0;

endpackage

/* rtl/reliability_aware_core_mapper_top.sv */
// Top level: config register, front end, command queue and back end.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  input    | in_valid_i / in_ready_o    | mode, core_index, reliability, core_count,
//           |                            | free_mask, active_mask
//  output   | out_valid_o / out_ready_i  | kind, from_core, to_core, last
//  config   | psel, penable, pwrite      | paddr, pwdata, prdata (pready tied high)
//
// An update is written to the table straight from idle. Each pick is one scan of the
// reliability table through its single read port, followed by an emit. A sweep
// checks every core in turn and runs one scan for each active core below the
// threshold, with one emit per migration and a final done emit.
// Reset clears the table valid bits, threshold and all control.
// The two-entry command queue and the output register let either side stall.
module reliability_aware_core_mapper_top import rcm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            mode_i,
  input  logic [CORE_W-1:0]     core_index_i,
  input  logic [REL_W-1:0]      reliability_i,
  input  logic [CNT_W-1:0]      core_count_i,
  input  logic [MASK_W-1:0]     free_mask_i,
  input  logic [MASK_W-1:0]     active_mask_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            kind_o,
  output logic [CORE_W-1:0]     from_core_o,
  output logic [CORE_W-1:0]     to_core_o,
  output logic                  last_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [REL_W-1:0] threshold_q;
  logic             cfg_wr;
  logic             f_valid, f_ready, b_valid, b_ready;
  cmd_t             f_cmd, b_cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[CFG_ADDR_W-1] == CFG_IDX_THRESHOLD);
  assign prdata = (paddr[CFG_ADDR_W-1] == CFG_IDX_THRESHOLD) ?
                  {{(32-REL_W){1'b0}}, threshold_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
    end else if (cfg_wr) begin
      threshold_q <= pwdata[REL_W-1:0];
    end
  end

  rcm_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .core_index_i  (core_index_i),
    .reliability_i (reliability_i),
    .core_count_i  (core_count_i),
    .free_mask_i   (free_mask_i),
    .active_mask_i (active_mask_i),
    .cmd_valid_o   (f_valid),
    .cmd_o         (f_cmd),
    .cmd_ready_i   (f_ready)
  );

  rcm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_cmd)
  );

  rcm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .threshold_i (threshold_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .from_core_o (from_core_o),
    .to_core_o   (to_core_o),
    .last_o      (last_o)
  );

endmodule

/* rtl/rcm_front.sv */
// Front end: accepts input transactions and classifies them into commands.
module rcm_front import rcm_pkg::*; (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        mode_i,
  input  logic [CORE_W-1:0] core_index_i,
  input  logic [REL_W-1:0]  reliability_i,
  input  logic [CNT_W-1:0]  core_count_i,
  input  logic [MASK_W-1:0] free_mask_i,
  input  logic [MASK_W-1:0] active_mask_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_ready_i
);

  logic [MASK_W-1:0] free_m;
  logic [CNT_W-1:0]  avail;
  mode_e             mode;

  assign mode   = mode_e'(mode_i);
  assign free_m = free_mask_i & CORE_MASK;

  always_comb begin
    avail = '0;
    for (int c = 0; c < MASK_W; c++) begin
      avail = avail + CNT_W'(free_m[c]);
    end
  end

  always_comb begin
    cmd_o.core_index  = core_index_i;
    cmd_o.reliability = reliability_i;
    cmd_o.core_count  = core_count_i;
    cmd_o.free_mask   = free_m;
    cmd_o.active_mask = active_mask_i & CORE_MASK;
    case (mode)
      MODE_UPDATE: cmd_o.op = OP_UPDATE;
      MODE_MAP: begin
        if (core_count_i == '0) begin
          cmd_o.op = OP_EMPTY;
        end else if (core_count_i > avail) begin
          cmd_o.op = OP_FAIL;
        end else begin
          cmd_o.op = OP_MAP;
        end
      end
      MODE_SWEEP: cmd_o.op = OP_SWEEP;
      default: cmd_o.op = OP_UPDATE;
    endcase
  end

  // mode 3 is taken and dropped
  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i && (mode != MODE_UNUSED);

endmodule

/* rtl/rcm_queue.sv */
// Short command queue between the front end and the back end.
module rcm_queue import rcm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  cmd_t                   mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                   push, pop;

  assign push_ready_o = (cnt_q != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/rcm_back.sv */
// Back end: reliability table, argmax scan sequencer and result register.
module rcm_back import rcm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  cmd_t              cmd_i,
  input  logic [REL_W-1:0]  threshold_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        kind_o,
  output logic [CORE_W-1:0] from_core_o,
  output logic [CORE_W-1:0] to_core_o,
  output logic              last_o
);

  // reliability table; entries never written read as zero
  logic [REL_W-1:0]  rel_mem [MAX_CORES];
  logic [MAX_CORES-1:0] rel_vld_q, rel_vld_d;
  logic              rel_we;
  logic [CORE_W-1:0] rd_addr;
  logic [REL_W-1:0]  rd_data_q;

  back_state_e       state_q, state_d;
  cmd_t              cur_q, cur_d;
  logic [MASK_W-1:0] mask_q, mask_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  src_q, src_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic              pend_vld_q, pend_vld_d;
  logic [CORE_W-1:0] pend_idx_q, pend_idx_d;
  logic              best_vld_q, best_vld_d;
  logic [CORE_W-1:0] best_idx_q, best_idx_d;
  logic [REL_W-1:0]  best_val_q, best_val_d;

  kind_e             res_kind_q, res_kind_d;
  logic [CORE_W-1:0] res_from_q, res_from_d;
  logic [CORE_W-1:0] res_to_q, res_to_d;
  logic              res_last_q, res_last_d;

  logic              out_vld_q, out_vld_d;
  kind_e             out_kind_q;
  logic [CORE_W-1:0] out_from_q, out_to_q;
  logic              out_last_q;
  logic              can_load, load_out, scan_done;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign can_load    = !out_vld_q || out_ready_i;
  assign scan_done   = (scan_q == NUM_CORES_C) && !pend_vld_q;
  assign rd_addr     = (state_q == ST_CHECK) ? src_q[CORE_W-1:0] : scan_q[CORE_W-1:0];

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    mask_d     = mask_q;
    cnt_d      = cnt_q;
    src_d      = src_q;
    scan_d     = scan_q;
    best_vld_d = best_vld_q;
    best_idx_d = best_idx_q;
    best_val_d = best_val_q;
    res_kind_d = res_kind_q;
    res_from_d = res_from_q;
    res_to_d   = res_to_q;
    res_last_d = res_last_q;
    rel_we     = 1'b0;
    load_out   = 1'b0;
    pend_vld_d = (state_q == ST_SCAN) && (scan_q != NUM_CORES_C);
    pend_idx_d = scan_q[CORE_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cur_d      = cmd_i;
          mask_d     = cmd_i.free_mask;
          cnt_d      = cmd_i.core_count;
          src_d      = '0;
          res_from_d = '0;
          res_to_d   = '0;
          res_last_d = 1'b1;
          case (cmd_i.op)
            OP_UPDATE: rel_we = 1'b1;
            OP_EMPTY: begin
              res_kind_d = KIND_EMPTY;
              state_d    = ST_EMIT;
            end
            OP_FAIL: begin
              res_kind_d = KIND_FAIL;
              state_d    = ST_EMIT;
            end
            OP_MAP:   state_d = ST_SCAN;
            OP_SWEEP: state_d = ST_NEXT_SRC;
            default:  state_d = ST_IDLE;
          endcase
        end
      end

      ST_NEXT_SRC: begin
        if (src_q == NUM_CORES_C) begin
          res_kind_d = KIND_DONE;
          res_from_d = '0;
          res_to_d   = '0;
          res_last_d = 1'b1;
          state_d    = ST_EMIT;
        end else begin
          state_d = ST_CHECK;
        end
      end

      ST_CHECK: state_d = ST_CHECK_WAIT;

      ST_CHECK_WAIT: begin
        if (cur_q.active_mask[src_q[CORE_W-1:0]] && (rd_data_q < threshold_i)) begin
          state_d = ST_SCAN;
        end else begin
          src_d   = src_q + 1'b1;
          state_d = ST_NEXT_SRC;
        end
      end

      ST_SCAN: begin
        if (scan_q != NUM_CORES_C) begin
          scan_d = scan_q + 1'b1;
        end
        // one compare per cycle, read data arrives in the cycle after its address
        if (pend_vld_q && mask_q[pend_idx_q] &&
            (!best_vld_q || (rd_data_q > best_val_q))) begin
          best_vld_d = 1'b1;
          best_idx_d = pend_idx_q;
          best_val_d = rd_data_q;
        end
        if (scan_done) begin
          if (cur_q.op == OP_MAP) begin
            res_kind_d         = KIND_ASSIGN;
            res_from_d         = '0;
            res_to_d           = best_idx_q;
            res_last_d         = (cnt_q == CNT_W'(1));
            mask_d[best_idx_q] = 1'b0;
            cnt_d              = cnt_q - 1'b1;
            state_d            = ST_EMIT;
          end else if (best_vld_q) begin
            res_kind_d         = KIND_MIGRATE;
            res_from_d         = src_q[CORE_W-1:0];
            res_to_d           = best_idx_q;
            res_last_d         = 1'b0;
            mask_d[best_idx_q] = 1'b0;
            src_d              = src_q + 1'b1;
            state_d            = ST_EMIT;
          end else begin
            src_d   = src_q + 1'b1;
            state_d = ST_NEXT_SRC;
          end
        end
      end

      ST_EMIT: begin
        if (can_load) begin
          load_out = 1'b1;
          if (res_last_q) begin
            state_d = ST_IDLE;
          end else if (cur_q.op == OP_MAP) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_NEXT_SRC;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // fresh scan on entry
    if ((state_q != ST_SCAN) && (state_d == ST_SCAN)) begin
      scan_d     = '0;
      best_vld_d = 1'b0;
    end

    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_comb begin
    rel_vld_d = rel_vld_q;
    if (rel_we) begin
      rel_vld_d[cmd_i.core_index] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rel_vld_q  <= '0;
      pend_vld_q <= 1'b0;
      best_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      scan_q     <= '0;
      src_q      <= '0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      rel_vld_q  <= rel_vld_d;
      pend_vld_q <= pend_vld_d;
      best_vld_q <= best_vld_d;
      out_vld_q  <= out_vld_d;
      scan_q     <= scan_d;
      src_q      <= src_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    mask_q     <= mask_d;
    pend_idx_q <= pend_idx_d;
    best_idx_q <= best_idx_d;
    best_val_q <= best_val_d;
    res_kind_q <= res_kind_d;
    res_from_q <= res_from_d;
    res_to_q   <= res_to_d;
    res_last_q <= res_last_d;
    if (load_out) begin
      out_kind_q <= res_kind_q;
      out_from_q <= res_from_q;
      out_to_q   <= res_to_q;
      out_last_q <= res_last_q;
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (rel_we) begin
      rel_mem[cmd_i.core_index] <= cmd_i.reliability;
    end
    rd_data_q <= rel_vld_q[rd_addr] ? rel_mem[rd_addr] : '0;
  end

  assign out_valid_o = out_vld_q;
  assign kind_o      = out_kind_q;
  assign from_core_o = out_from_q;
  assign to_core_o   = out_to_q;
  assign last_o      = out_last_q;

  // a map request was pre-checked, so every pick must find a core
  a_map_pick_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && scan_done && cur_q.op == OP_MAP) |-> best_vld_q)
    else $error("map scan ended without a free core");

  a_best_in_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && best_vld_q) |-> mask_q[best_idx_q])
    else $error("scan winner is not in the working mask");

  a_from_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_kind_q != KIND_MIGRATE) |-> (out_from_q == '0))
    else $error("from_core set on a non-migration result");

  a_no_pop_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |=> (state_q != ST_IDLE || $past(load_out) ||
                              $past(state_q) == ST_SCAN || $past(state_q) == ST_CHECK_WAIT))
    else $error("sequencer returned to idle without finishing a command");

endmodule
